// ===== design/lobm_pkg.sv =====
// Shared types and constants for the limit order book matcher.
// Holds the sequencer state type, report codes and field widths.
// Depends on nothing; the top-level matcher file refers to it by scoped name.
package lobm_pkg;

    // Field widths of the request and report channels.
    localparam int PRICE_W = 10;
    localparam int QTY_W   = 16;
    localparam int ID_W    = 32;
    localparam int SEQ_W   = 32;

    // Default book dimensions.
    localparam int DEF_PRICE_LEVELS = 1024;
    localparam int DEF_ORDER_SLOTS  = 64;

    // The walk stops after this many fills for one incoming order.
    localparam int FILL_W    = 6;
    localparam int MAX_FILLS = 63;

    // Report codes.
    typedef enum logic [1:0] {
        KIND_FILL   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_REST   = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ZERO,
        S_WALK,
        S_LVL,
        S_HIT,
        S_REST_CHK,
        S_REST,
        S_LINK,
        S_REJ
    } t_state;

endpackage

// ===== design/lobm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the price level table and the resting order slots.
// No dependencies.
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== design/lobm_link.sv =====
// Slot link store: next pointer of each order slot, for level queues and free list.
// Wraps one lobm_ram; per-entry valid bits make unwritten entries read as the
// reset free-list chain. Depends on lobm_ram.
module lobm_link #(
    parameter int SLOTS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [$clog2(SLOTS)-1:0]     i_waddr,
    input  logic [$clog2(SLOTS+1)-1:0]   i_wdata,
    input  logic [$clog2(SLOTS)-1:0]     i_raddr,
    output logic [$clog2(SLOTS+1)-1:0]   o_rdata
);

    localparam int SA = $clog2(SLOTS);
    localparam int SW = $clog2(SLOTS + 1);

    logic [SLOTS-1:0] r_valid;
    logic [SA-1:0]    r_raddr;
    logic [SW-1:0]    ram_q;

    lobm_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_raddr),
        .o_rdata (ram_q)
    );

    // Valid bits are cleared at reset; the read address is kept to select them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
        r_raddr <= i_raddr;
    end

    // An entry never written holds its place in the initial free-list chain.
    assign o_rdata = r_valid[r_raddr] ? ram_q : SW'(r_raddr) + SW'(1);

endmodule

// ===== design/limit_order_book_matcher.sv =====
// Limit order book matcher with price-time priority.
// Top level: sequencer, book registers and output register.
// Depends on lobm_pkg, lobm_ram and lobm_link.
//
// Usage. A new limit order is a request on the input channel (i_in_valid /
// o_in_ready): side, limit price, quantity and client id. It crosses the
// opposite side of the book and produces one or more reports on the output
// channel (o_out_valid / i_out_ready): a fill per hit that leaves quantity,
// then a completion, rest or reject. last_report marks the final one.
// Timing. Levels are visited one table read at a time, each by a bound check
// and a level read; each fill adds a trade step, and a check and a write rest
// the remainder. The next request is taken once the final report has been
// registered, or after a link step when a rested order is linked behind
// others at its level.
// Reset. After reset the level table is cleared one level per cycle; no
// request is taken meanwhile.
// Stalls. Reports sit in one output register; while the receiver stalls, the
// sequencer holds before it makes the next report.
module limit_order_book_matcher #(
    parameter int PRICE_LEVELS = lobm_pkg::DEF_PRICE_LEVELS,
    parameter int ORDER_SLOTS  = lobm_pkg::DEF_ORDER_SLOTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_side,
    input  logic [lobm_pkg::PRICE_W-1:0] i_limit_price,
    input  logic [lobm_pkg::QTY_W-1:0]   i_order_quantity,
    input  logic [lobm_pkg::ID_W-1:0]    i_client_order_id,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_report_kind,
    output logic [lobm_pkg::ID_W-1:0]    o_maker_order_id,
    output logic [lobm_pkg::PRICE_W-1:0] o_trade_price,
    output logic [lobm_pkg::QTY_W-1:0]   o_trade_quantity,
    output logic [lobm_pkg::QTY_W-1:0]   o_left_quantity,
    output logic [lobm_pkg::SEQ_W-1:0]   o_sequence_number,
    output logic                         o_last_report
);

    localparam int LW = $clog2(PRICE_LEVELS);
    localparam int CW = LW + 1;
    localparam int XW = (CW > lobm_pkg::PRICE_W + 1) ? CW : lobm_pkg::PRICE_W + 1;
    localparam int SA = $clog2(ORDER_SLOTS);
    localparam int SW = $clog2(ORDER_SLOTS + 1);
    localparam int QW = lobm_pkg::QTY_W;
    localparam int IW = lobm_pkg::ID_W;
    localparam int DW = QW + IW;

    localparam logic [SW-1:0] EMPTY = SW'(ORDER_SLOTS);

    // Sequencer and book registers.
    lobm_pkg::t_state r_state, n_state;
    logic                         r_side, n_side;
    logic [XW-1:0]                r_price, n_price;
    logic [QW-1:0]                r_left, n_left;
    logic [IW-1:0]                r_id, n_id;
    logic [CW-1:0]                r_best_ask, n_best_ask;
    logic [CW-1:0]                r_best_bid, n_best_bid;
    logic [CW-1:0]                r_cur, n_cur;
    logic [SW-1:0]                r_free, n_free;
    logic [lobm_pkg::SEQ_W-1:0]   r_count, n_count;
    logic [lobm_pkg::FILL_W-1:0]  r_nfill, n_nfill;
    logic [SW-1:0]                r_head, n_head;
    logic [SW-1:0]                r_tail, n_tail;
    logic [SW-1:0]                r_slot, n_slot;
    logic [LW-1:0]                r_clr, n_clr;

    // Output register.
    logic                         r_o_valid;
    lobm_pkg::t_kind              r_o_kind;
    logic [IW-1:0]                r_o_maker;
    logic [lobm_pkg::PRICE_W-1:0] r_o_price;
    logic [QW-1:0]                r_o_tq;
    logic [QW-1:0]                r_o_left;
    logic [lobm_pkg::SEQ_W-1:0]   r_o_seq;
    logic                         r_o_last;

    // Report being made this cycle.
    logic                         emit;
    lobm_pkg::t_kind              e_kind;
    logic [IW-1:0]                e_maker;
    logic [QW-1:0]                e_tq;
    logic [QW-1:0]                e_left;
    logic [lobm_pkg::SEQ_W-1:0]   e_seq;
    logic                         e_last;

    // Memory ports.
    logic          lvl_we;
    logic [LW-1:0] lvl_waddr, lvl_raddr;
    logic [2*SW-1:0] lvl_wdata, lvl_rdata;
    logic          slt_we;
    logic [SA-1:0] slt_waddr, slt_raddr;
    logic [DW-1:0] slt_wdata, slt_rdata;
    logic          lnk_we;
    logic [SA-1:0] lnk_waddr, lnk_raddr;
    logic [SW-1:0] lnk_wdata, lnk_rdata;

    // Helper signals.
    logic          can_emit;
    logic          accept;
    logic [CW-1:0] walk;
    logic [SW-1:0] q_head, q_tail;
    logic          q_empty;
    logic [QW-1:0] s_qty, take, rem, nleft;
    logic          nx_empty;
    logic [XW-1:0] ext_price, sat_price;
    logic [CW-1:0] start_cur;

    assign can_emit  = !r_o_valid || i_out_ready;
    assign accept    = i_in_valid && o_in_ready;
    assign walk      = r_side ? r_cur : r_best_ask;
    assign q_head    = lvl_rdata[2*SW-1:SW];
    assign q_tail    = lvl_rdata[SW-1:0];
    assign q_empty   = q_head >= EMPTY;
    assign s_qty     = slt_rdata[DW-1:IW];
    assign take      = (s_qty < r_left) ? s_qty : r_left;
    assign rem       = s_qty - take;
    assign nleft     = r_left - take;
    assign nx_empty  = lnk_rdata >= EMPTY;
    assign ext_price = XW'(i_limit_price);
    assign sat_price = (ext_price >= XW'(PRICE_LEVELS)) ? XW'(PRICE_LEVELS - 1) : ext_price;
    assign start_cur = (r_best_bid >= r_best_ask) ? r_best_ask - CW'(1) : r_best_bid;

    lobm_ram #(
        .WIDTH (2 * SW),
        .DEPTH (PRICE_LEVELS)
    ) u_level (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (lvl_waddr),
        .i_wdata (lvl_wdata),
        .i_raddr (lvl_raddr),
        .o_rdata (lvl_rdata)
    );

    lobm_ram #(
        .WIDTH (DW),
        .DEPTH (ORDER_SLOTS)
    ) u_slot (
        .i_clk   (i_clk),
        .i_we    (slt_we),
        .i_waddr (slt_waddr),
        .i_wdata (slt_wdata),
        .i_raddr (slt_raddr),
        .o_rdata (slt_rdata)
    );

    lobm_link #(
        .SLOTS (ORDER_SLOTS)
    ) u_link (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (lnk_we),
        .i_waddr (lnk_waddr),
        .i_wdata (lnk_wdata),
        .i_raddr (lnk_raddr),
        .o_rdata (lnk_rdata)
    );

    // State and book registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lobm_pkg::S_CLEAR;
            r_best_ask <= CW'(PRICE_LEVELS);
            r_best_bid <= '0;
            r_free     <= '0;
            r_count    <= '0;
            r_clr      <= '0;
            r_nfill    <= '0;
        end else begin
            r_state    <= n_state;
            r_best_ask <= n_best_ask;
            r_best_bid <= n_best_bid;
            r_free     <= n_free;
            r_count    <= n_count;
            r_clr      <= n_clr;
            r_nfill    <= n_nfill;
        end
        r_side  <= n_side;
        r_price <= n_price;
        r_left  <= n_left;
        r_id    <= n_id;
        r_cur   <= n_cur;
        r_head  <= n_head;
        r_tail  <= n_tail;
        r_slot  <= n_slot;
    end

    // Next state, memory accesses and reports.
    always_comb begin
        n_state    = r_state;
        n_side     = r_side;
        n_price    = r_price;
        n_left     = r_left;
        n_id       = r_id;
        n_best_ask = r_best_ask;
        n_best_bid = r_best_bid;
        n_cur      = r_cur;
        n_free     = r_free;
        n_count    = r_count;
        n_nfill    = r_nfill;
        n_head     = r_head;
        n_tail     = r_tail;
        n_slot     = r_slot;
        n_clr      = r_clr;

        o_in_ready = 1'b0;

        lvl_we    = 1'b0;
        lvl_waddr = walk[LW-1:0];
        lvl_wdata = {EMPTY, EMPTY};
        lvl_raddr = walk[LW-1:0];
        slt_we    = 1'b0;
        slt_waddr = r_head[SA-1:0];
        slt_wdata = {rem, slt_rdata[IW-1:0]};
        slt_raddr = r_head[SA-1:0];
        lnk_we    = 1'b0;
        lnk_waddr = r_head[SA-1:0];
        lnk_wdata = r_free;
        lnk_raddr = r_head[SA-1:0];

        emit    = 1'b0;
        e_kind  = lobm_pkg::KIND_FILL;
        e_maker = '0;
        e_tq    = '0;
        e_left  = r_left;
        e_seq   = '0;
        e_last  = 1'b1;

        unique case (r_state)
            lobm_pkg::S_CLEAR: begin
                lvl_we    = 1'b1;
                lvl_waddr = r_clr;
                n_clr     = r_clr + LW'(1);
                if (r_clr == LW'(PRICE_LEVELS - 1)) begin
                    n_state = lobm_pkg::S_IDLE;
                end
            end

            lobm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    n_side  = i_side;
                    n_price = sat_price;
                    n_left  = i_order_quantity;
                    n_id    = i_client_order_id;
                    n_nfill = '0;
                    if (i_order_quantity == '0) begin
                        n_state = lobm_pkg::S_ZERO;
                    end else if (!i_side) begin
                        n_state = lobm_pkg::S_WALK;
                    end else if (r_best_ask == '0) begin
                        n_state = lobm_pkg::S_REST_CHK;
                    end else if (sat_price > XW'(start_cur)) begin
                        n_state = lobm_pkg::S_REST_CHK;
                    end else begin
                        n_cur   = start_cur;
                        n_state = lobm_pkg::S_WALK;
                    end
                end
            end

            lobm_pkg::S_ZERO: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    e_kind  = lobm_pkg::KIND_DONE;
                    e_left  = '0;
                    e_seq   = r_count + 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = lobm_pkg::S_IDLE;
                end
            end

            // Check the walk bound, then read the level at the walk position.
            lobm_pkg::S_WALK: begin
                if (!r_side) begin
                    n_state = (XW'(r_best_ask) > r_price) ? lobm_pkg::S_REST_CHK
                                                           : lobm_pkg::S_LVL;
                end else if (XW'(r_cur) < r_price) begin
                    n_best_bid = r_cur;
                    n_state    = lobm_pkg::S_REST_CHK;
                end else begin
                    n_state = lobm_pkg::S_LVL;
                end
            end

            // Skip an empty level, reject at the fill cap, or fetch the oldest order resting there.
            lobm_pkg::S_LVL: begin
                slt_raddr = q_head[SA-1:0];
                lnk_raddr = q_head[SA-1:0];
                if (q_empty) begin
                    if (!r_side) begin
                        n_best_ask = r_best_ask + CW'(1);
                        n_state    = lobm_pkg::S_WALK;
                    end else if (r_cur == '0) begin
                        n_best_bid = r_cur;
                        n_state    = lobm_pkg::S_REST_CHK;
                    end else begin
                        n_cur   = r_cur - CW'(1);
                        n_state = lobm_pkg::S_WALK;
                    end
                end else if (r_nfill == lobm_pkg::FILL_W'(lobm_pkg::MAX_FILLS)) begin
                    if (r_side) begin
                        n_best_bid = r_cur;
                    end
                    n_state = lobm_pkg::S_REJ;
                end else begin
                    n_head  = q_head;
                    n_tail  = q_tail;
                    n_state = lobm_pkg::S_HIT;
                end
            end

            // Trade against the head order; a filled maker returns to the free list.
            lobm_pkg::S_HIT: begin
                if (can_emit) begin
                    slt_we = 1'b1;
                    if (rem == '0) begin
                        lvl_we    = 1'b1;
                        lvl_wdata = nx_empty ? {EMPTY, EMPTY} : {lnk_rdata, r_tail};
                        lnk_we    = 1'b1;
                        n_free    = r_head;
                    end
                    emit    = 1'b1;
                    e_maker = slt_rdata[IW-1:0];
                    e_tq    = take;
                    e_left  = nleft;
                    n_left  = nleft;
                    if (nleft == '0) begin
                        e_kind  = lobm_pkg::KIND_DONE;
                        e_seq   = r_count + 1'b1;
                        n_count = r_count + 1'b1;
                        if (r_side) begin
                            n_best_bid = r_cur;
                        end
                        n_state = lobm_pkg::S_IDLE;
                    end else begin
                        e_kind  = lobm_pkg::KIND_FILL;
                        e_last  = 1'b0;
                        n_nfill = r_nfill + 1'b1;
                        n_state = lobm_pkg::S_WALK;
                    end
                end
            end

            // Read the free head's link and the target level; reject if no slot is free.
            lobm_pkg::S_REST_CHK: begin
                lvl_raddr = r_price[LW-1:0];
                lnk_raddr = r_free[SA-1:0];
                n_state   = (r_free >= EMPTY) ? lobm_pkg::S_REJ : lobm_pkg::S_REST;
            end

            // Place the remainder in the free slot at the tail of its level.
            lobm_pkg::S_REST: begin
                lvl_raddr = r_price[LW-1:0];
                lnk_raddr = r_free[SA-1:0];
                if (can_emit) begin
                    slt_we    = 1'b1;
                    slt_waddr = r_free[SA-1:0];
                    slt_wdata = {r_left, r_id};
                    lnk_we    = 1'b1;
                    lnk_waddr = r_free[SA-1:0];
                    lnk_wdata = EMPTY;
                    lvl_we    = 1'b1;
                    lvl_waddr = r_price[LW-1:0];
                    n_free    = lnk_rdata;
                    if (q_empty) begin
                        lvl_wdata = {r_free, r_free};
                        n_state   = lobm_pkg::S_IDLE;
                    end else begin
                        lvl_wdata = {q_head, r_free};
                        n_tail    = q_tail;
                        n_slot    = r_free;
                        n_state   = lobm_pkg::S_LINK;
                    end
                    if (!r_side) begin
                        if (r_price > XW'(r_best_bid)) begin
                            n_best_bid = CW'(r_price);
                        end
                    end else if (r_price < XW'(r_best_ask)) begin
                        n_best_ask = CW'(r_price);
                    end
                    emit    = 1'b1;
                    e_kind  = lobm_pkg::KIND_REST;
                    e_seq   = r_count + 1'b1;
                    n_count = r_count + 1'b1;
                end
            end

            // Chain the old tail to the newly rested slot.
            lobm_pkg::S_LINK: begin
                lnk_we    = 1'b1;
                lnk_waddr = r_tail[SA-1:0];
                lnk_wdata = r_slot;
                n_state   = lobm_pkg::S_IDLE;
            end

            lobm_pkg::S_REJ: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    e_kind  = lobm_pkg::KIND_REJECT;
                    n_state = lobm_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = lobm_pkg::S_IDLE;
            end
        endcase
    end

    // Output register: loaded with each report, cleared when it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
        if (emit) begin
            r_o_kind  <= e_kind;
            r_o_maker <= e_maker;
            r_o_price <= r_price[lobm_pkg::PRICE_W-1:0];
            r_o_tq    <= e_tq;
            r_o_left  <= e_left;
            r_o_seq   <= e_seq;
            r_o_last  <= e_last;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_report_kind     = r_o_kind;
    assign o_maker_order_id  = r_o_maker;
    assign o_trade_price     = r_o_price;
    assign o_trade_quantity  = r_o_tq;
    assign o_left_quantity   = r_o_left;
    assign o_sequence_number = r_o_seq;
    assign o_last_report     = r_o_last;

    // A report that is not the last one leaves the sequencer busy.
    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !e_last) |=> (r_state != lobm_pkg::S_IDLE))
        else $error("sequencer idle after an intermediate report");

    // The free list head is a slot or the empty mark.
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free <= EMPTY))
        else $error("free list head out of range");

    // A buy never reads a level beyond the book.
    a_buy_in_book: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lobm_pkg::S_LVL && !r_side) |-> (r_best_ask < CW'(PRICE_LEVELS)))
        else $error("buy walk read beyond the book");

    // An accepted request is not followed by another in the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("second request taken while busy");

endmodule

// ===== tb/limit_order_book_matcher_tb.sv =====
// Testbench for the limit order book matcher: random and directed orders with a
// self-checking scoreboard that keeps its own copy of the book.
// Depends on lobm_pkg and the limit_order_book_matcher design files.
`timescale 1ns / 1ps

module limit_order_book_matcher_tb;

    localparam int LEVELS    = lobm_pkg::DEF_PRICE_LEVELS;
    localparam int SLOTS     = lobm_pkg::DEF_ORDER_SLOTS;
    localparam int FILL_CAP  = lobm_pkg::MAX_FILLS;
    localparam int WDOG_MAX  = 20000;
    localparam int RAND_REQS = 390;
    localparam int DUE_DEPTH = 256;

    // One report as it leaves the block.
    typedef struct {
        lobm_pkg::t_kind                kind;
        logic [lobm_pkg::ID_W-1:0]      maker;
        logic [lobm_pkg::PRICE_W-1:0]   price;
        logic [lobm_pkg::QTY_W-1:0]     traded;
        logic [lobm_pkg::QTY_W-1:0]     left;
        logic [lobm_pkg::SEQ_W-1:0]     seq;
        logic                           last;
    } t_report;

    // Book model and the ring of reports it predicts.
    class t_book_scoreboard;
        int unsigned                ask_top;
        int unsigned                bid_top;
        int unsigned                head_of[LEVELS];
        int unsigned                tail_of[LEVELS];
        int unsigned                qty_of[SLOTS];
        logic [lobm_pkg::ID_W-1:0]  id_of[SLOTS];
        int unsigned                next_of[SLOTS];
        int unsigned                free_slot;
        logic [lobm_pkg::SEQ_W-1:0] order_count;
        t_report                    due_ring[DUE_DEPTH];
        int unsigned                due_wr;
        int unsigned                due_rd;
        int                         errors;

        function new();
            ask_top = LEVELS;
            bid_top = 0;
            for (int i = 0; i < LEVELS; i++) begin
                head_of[i] = SLOTS;
                tail_of[i] = SLOTS;
            end
            for (int i = 0; i < SLOTS; i++) begin
                qty_of[i]  = 0;
                id_of[i]   = '0;
                next_of[i] = i + 1;
            end
            free_slot   = 0;
            order_count = '0;
            due_wr      = 0;
            due_rd      = 0;
            errors      = 0;
        endfunction

        // Number of predicted reports still to arrive.
        function int unsigned pending();
            return due_wr - due_rd;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        function void push(lobm_pkg::t_kind k, logic [lobm_pkg::ID_W-1:0] mk,
                           int unsigned pr, int unsigned tq, int unsigned lq,
                           logic [lobm_pkg::SEQ_W-1:0] sq, logic ls);
            t_report r;
            r.kind   = k;
            r.maker  = mk;
            r.price  = pr[lobm_pkg::PRICE_W-1:0];
            r.traded = tq[lobm_pkg::QTY_W-1:0];
            r.left   = lq[lobm_pkg::QTY_W-1:0];
            r.seq    = sq;
            r.last   = ls;
            due_ring[due_wr % DUE_DEPTH] = r;
            due_wr++;
        endfunction

        // Trade against the oldest order at a level; a filled maker is freed.
        function int unsigned take_head(int unsigned lvl, int unsigned want,
                                        output logic [lobm_pkg::ID_W-1:0] mk);
            int unsigned h;
            int unsigned q;
            int unsigned tk;
            h  = head_of[lvl];
            q  = qty_of[h];
            tk = (q < want) ? q : want;
            mk = id_of[h];
            qty_of[h] = q - tk;
            if (qty_of[h] == 0) begin
                head_of[lvl] = next_of[h];
                if (head_of[lvl] >= SLOTS) begin
                    head_of[lvl] = SLOTS;
                    tail_of[lvl] = SLOTS;
                end
                next_of[h] = free_slot;
                free_slot  = h;
            end
            return tk;
        endfunction

        // Work out every report that one accepted request causes.
        function void note_request(logic sd, logic [lobm_pkg::PRICE_W-1:0] lp,
                                   logic [lobm_pkg::QTY_W-1:0] oq,
                                   logic [lobm_pkg::ID_W-1:0] cid);
            int unsigned pr;
            int unsigned left;
            int unsigned tk;
            int unsigned cur;
            int unsigned s;
            int          n;
            bit          cut;
            logic [lobm_pkg::ID_W-1:0] mk;
            pr   = lp;
            left = oq;
            n    = 0;
            cut  = 0;
            if (pr >= LEVELS) pr = LEVELS - 1;
            if (left == 0) begin
                order_count++;
                push(lobm_pkg::KIND_DONE, '0, pr, 0, 0, order_count, 1'b1);
                return;
            end
            if (sd == 1'b0) begin
                // A buy climbs the ask levels.
                while (ask_top <= pr) begin
                    if (head_of[ask_top] >= SLOTS) begin
                        ask_top++;
                        continue;
                    end
                    if (n >= FILL_CAP) begin
                        cut = 1;
                        break;
                    end
                    tk   = take_head(ask_top, left, mk);
                    left -= tk;
                    if (left == 0) begin
                        order_count++;
                        push(lobm_pkg::KIND_DONE, mk, pr, tk, 0, order_count, 1'b1);
                        return;
                    end
                    push(lobm_pkg::KIND_FILL, mk, pr, tk, left, '0, 1'b0);
                    n++;
                end
            end else if (ask_top > 0) begin
                // A sell descends the bid levels, never below level zero.
                cur = bid_top;
                if (cur >= ask_top) cur = ask_top - 1;
                if (pr <= cur) begin
                    forever begin
                        if (cur < pr) break;
                        if (head_of[cur] >= SLOTS) begin
                            if (cur == 0) break;
                            cur--;
                            continue;
                        end
                        if (n >= FILL_CAP) begin
                            cut = 1;
                            break;
                        end
                        tk   = take_head(cur, left, mk);
                        left -= tk;
                        if (left == 0) begin
                            bid_top = cur;
                            order_count++;
                            push(lobm_pkg::KIND_DONE, mk, pr, tk, 0, order_count, 1'b1);
                            return;
                        end
                        push(lobm_pkg::KIND_FILL, mk, pr, tk, left, '0, 1'b0);
                        n++;
                    end
                    bid_top = cur;
                end
            end
            if (cut || free_slot >= SLOTS) begin
                push(lobm_pkg::KIND_REJECT, '0, pr, 0, left, '0, 1'b1);
                return;
            end
            // The remainder joins the tail of its level.
            s          = free_slot;
            free_slot  = next_of[s];
            qty_of[s]  = left;
            id_of[s]   = cid;
            next_of[s] = SLOTS;
            if (head_of[pr] >= SLOTS) head_of[pr] = s;
            else next_of[tail_of[pr] % SLOTS] = s;
            tail_of[pr] = s;
            if (sd == 1'b0) begin
                if (pr > bid_top) bid_top = pr;
            end else begin
                if (pr < ask_top) ask_top = pr;
            end
            order_count++;
            push(lobm_pkg::KIND_REST, '0, pr, 0, left, order_count, 1'b1);
        endfunction

        task check_report(t_report got);
            t_report e;
            if (pending() == 0) begin
                report_mismatch("report with none expected");
                return;
            end
            e = due_ring[due_rd % DUE_DEPTH];
            due_rd++;
            if (got.kind !== e.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", got.kind, e.kind));
            if (got.maker !== e.maker)
                report_mismatch($sformatf("maker %0h, expected %0h", got.maker, e.maker));
            if (got.price !== e.price)
                report_mismatch($sformatf("price %0d, expected %0d", got.price, e.price));
            if (got.traded !== e.traded)
                report_mismatch($sformatf("traded %0d, expected %0d", got.traded, e.traded));
            if (got.left !== e.left)
                report_mismatch($sformatf("left %0d, expected %0d", got.left, e.left));
            if (got.seq !== e.seq)
                report_mismatch($sformatf("sequence %0d, expected %0d", got.seq, e.seq));
            if (got.last !== e.last)
                report_mismatch($sformatf("last %0b, expected %0b", got.last, e.last));
        endtask
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic                         i_side;
    logic [lobm_pkg::PRICE_W-1:0] i_limit_price;
    logic [lobm_pkg::QTY_W-1:0]   i_order_quantity;
    logic [lobm_pkg::ID_W-1:0]    i_client_order_id;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic [1:0]                   o_report_kind;
    logic [lobm_pkg::ID_W-1:0]    o_maker_order_id;
    logic [lobm_pkg::PRICE_W-1:0] o_trade_price;
    logic [lobm_pkg::QTY_W-1:0]   o_trade_quantity;
    logic [lobm_pkg::QTY_W-1:0]   o_left_quantity;
    logic [lobm_pkg::SEQ_W-1:0]   o_sequence_number;
    logic                         o_last_report;

    t_book_scoreboard sb;
    int               send_idle_pct;
    int               recv_stall_pct;
    bit               hold_off_req;
    int               quiet_cycles;

    limit_order_book_matcher DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_side            (i_side),
        .i_limit_price     (i_limit_price),
        .i_order_quantity  (i_order_quantity),
        .i_client_order_id (i_client_order_id),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_report_kind     (o_report_kind),
        .o_maker_order_id  (o_maker_order_id),
        .o_trade_price     (o_trade_price),
        .o_trade_quantity  (o_trade_quantity),
        .o_left_quantity   (o_left_quantity),
        .o_sequence_number (o_sequence_number),
        .o_last_report     (o_last_report)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Offer one request, idling at random first, and wait until it is taken.
    task automatic send_order(logic sd, logic [lobm_pkg::PRICE_W-1:0] lp,
                              logic [lobm_pkg::QTY_W-1:0] oq,
                              logic [lobm_pkg::ID_W-1:0] cid);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_side            <= sd;
        i_limit_price     <= lp;
        i_order_quantity  <= oq;
        i_client_order_id <= cid;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(sd, lp, oq, cid);
    endtask

    // Hold the sender until every expected report has come back.
    task automatic drain_book_reports();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Random order, mostly close to a mid price so that sides cross often.
    task automatic send_random_order();
        logic [lobm_pkg::PRICE_W-1:0] lp;
        logic [lobm_pkg::QTY_W-1:0]   oq;
        int                           r;
        r  = $urandom_range(99);
        lp = (r < 85) ? lobm_pkg::PRICE_W'(500 + $urandom_range(40) - 20)
                      : lobm_pkg::PRICE_W'($urandom);
        r  = $urandom_range(99);
        if (r < 5)       oq = '0;
        else if (r < 10) oq = '1;
        else if (r < 20) oq = lobm_pkg::QTY_W'($urandom);
        else             oq = lobm_pkg::QTY_W'($urandom_range(200, 1));
        send_order(1'($urandom), lp, oq, $urandom);
    endtask

    // Stimulus.
    initial begin
        int n;
        sb                = new();
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_off_req      = 0;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_side            = 1'b0;
        i_limit_price     = '0;
        i_order_quantity  = '0;
        i_client_order_id = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero quantity, price extremes and a plain cross at the top level.
        send_order(1'b0, 10'd0, 16'd0, 32'h0);
        send_order(1'b1, 10'd1023, 16'd5, 32'hFFFF_FFFF);
        send_order(1'b0, 10'd1023, 16'd2, 32'h1234_5678);
        send_order(1'b0, 10'd1023, 16'd3, 32'h0000_0001);
        // A sell at level zero fully takes a bid resting at level zero.
        send_order(1'b0, 10'd0, 16'hFFFF, 32'hAAAA_5555);
        send_order(1'b1, 10'd0, 16'hFFFF, 32'h5555_AAAA);
        send_order(1'b0, 10'd1023, 16'hFFFF, 32'h0F0F_F0F0);
        drain_book_reports();

        // Small asks all trade against the bid resting at the top level, then two buys rest there.
        for (int i = 0; i < SLOTS + 1; i++)
            send_order(1'b1, 10'd700, 16'd1, 32'(1000 + i));
        send_order(1'b0, 10'd1023, 16'd100, 32'hBEEF_0001);
        send_order(1'b0, 10'd1023, 16'd1, 32'hBEEF_0002);
        drain_book_reports();

        // Random traffic over the idling phases.
        n = 0;
        while (n < RAND_REQS) begin
            case ((n / 40) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            if (n == 100) hold_off_req = 1;
            if (n == 200) drain_book_reports();
            if (n % 150 == 75) begin
                // Deep sweeps on both sides of the book.
                send_order(1'b0, 10'd1023, 16'hFFFF, $urandom);
                send_order(1'b1, 10'd0, 16'hFFFF, $urandom);
                n += 2;
            end else begin
                send_random_order();
                n++;
            end
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    // Report side: check accepted reports and stall at random, or throughout a hold-off when one is requested.
    initial begin
        t_report got;
        int      hold_left;
        i_out_ready = 1'b0;
        hold_left   = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.kind   = lobm_pkg::t_kind'(o_report_kind);
                got.maker  = o_maker_order_id;
                got.price  = o_trade_price;
                got.traded = o_trade_quantity;
                got.left   = o_left_quantity;
                got.seq    = o_sequence_number;
                got.last   = o_last_report;
                sb.check_report(got);
            end
            if (hold_off_req) begin
                hold_off_req = 0;
                hold_left    = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WDOG_MAX) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
design/lobm_pkg.sv
design/lobm_ram.sv
design/lobm_link.sv
design/limit_order_book_matcher.sv
tb/limit_order_book_matcher_tb.sv
